[src/hra_pkg.sv]
// Package for the histogram with running average block.
// Holds sizes, payload word types and the sequencer state type; no dependencies.
package hra_pkg;

  localparam int NUM_BINS = 128;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int DIVD_W   = 48;
  localparam int DIVR_W   = 16;
  localparam int DCNT_W   = $clog2(DIVD_W);

  // Commands
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_FOLD = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN   = 2'd0;
  localparam logic [1:0] REG_SCALE = 2'd1;
  localparam logic [1:0] REG_BINS  = 2'd2;

  localparam logic [31:0] MIN_RST   = 32'hFFFD_0000;
  localparam logic [31:0] SCALE_RST = 32'd1092267;
  localparam logic [7:0]  BINS_RST  = 8'd100;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] sample;
    logic [6:0]         bin_select;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  bin_index;
    logic        in_range;
    logic [15:0] bin_count;
    logic [31:0] bin_average;
    logic [15:0] run_number;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_LOOK, ST_RMW, ST_RD, ST_RDQ,
    ST_FRD, ST_FMUL, ST_FACC, ST_FDIV, ST_FWR, ST_OUT
  } state_t;

endpackage

[src/hra_div.sv]
// Bit-serial restoring divider, one quotient bit a cycle.
// Depends on hra_pkg for operand widths.
module hra_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hra_pkg::DIVD_W-1:0] dividend,
  input  logic [hra_pkg::DIVR_W-1:0] divisor,
  output logic                      done,
  output logic [hra_pkg::DIVD_W-1:0] quotient
);
  import hra_pkg::*;

  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVR_W-1:0] div_r;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DIVR_W:0]   sh;

  // Load on start, else one shift-and-subtract step while busy
  always_comb begin
    sh       = {rem_r, quo_r[DIVD_W-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, div_r}) begin
        rem_nxt = DIVR_W'(sh - {1'b0, div_r});
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DIVR_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIVD_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) div_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[src/histogram_with_running_average_unit.sv]
// Top level of the histogram with running average block.
// Depends on hra_pkg and hra_div.
//
// Usage: words enter on in_valid/in_ready and carry a command, a sample and
// a bin select. Each accepted word gives exactly one result word on
// out_valid/out_ready. Registers are written on cfg_valid/cfg_ready (always
// high); the user must write only while the block is idle (unchecked).
// Timing: the block takes one word at a time, in_ready is high only when the
// sequencer is idle. An add goes through multiply, bound check and count
// read, then write, and skips the write when the sample misses every bin; a
// read goes through the read and its registered data; other commands go
// straight to the output state. A fold walks all 128 bins, each through the
// shared 32x32 multiplier and the bit-serial 48-bit divider.
// Reset: registers take their defaults, the run number is zero and every bin
// reads as zero count and zero average through per-bin valid flags, so no
// clearing pass is needed.
// Stall: a result waits in the output register; the next word is accepted
// and worked on, and its result is held back until the receiver takes the
// previous one.
module histogram_with_running_average_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hra_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hra_pkg::out_word_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import hra_pkg::*;

  state_t state_r, state_nxt;

  logic [31:0] min_r, scale_r;
  logic [7:0]  bins_r;
  logic [15:0] runs_r;

  logic [1:0]  cmd_r;
  logic [31:0] smp_r;
  logic [6:0]  sel_r;
  logic        ok_r;
  logic [31:0] bin_r;
  logic [63:0] prod_r;
  logic [BIN_W-1:0] fb_r;

  logic [6:0]  res_idx_r;
  logic        res_hit_r;
  logic [15:0] res_cnt_r;
  logic [31:0] res_avg_r;

  logic      out_valid_r;
  out_word_t out_data_r;

  // Stores
  logic [15:0] cnt_mem [NUM_BINS];
  logic [31:0] avg_mem [NUM_BINS];
  logic [NUM_BINS-1:0] vld_r;
  logic [15:0] cnt_q;
  logic [31:0] avg_q;
  logic        vld_q;
  logic [15:0] cnt_rd;
  logic [31:0] avg_rd;

  // Control
  logic             in_fire, out_free;
  logic             rd_en, wr_en, load_out, div_start;
  logic [BIN_W-1:0] rd_addr, wr_addr;
  logic [15:0]      wr_cnt;
  logic [31:0]      wr_avg;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic [32:0]      diff;
  logic [7:0]       nb;
  logic             add_hit;
  logic             div_done;
  logic [DIVD_W-1:0] div_q;
  logic [DIVD_W-1:0] acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign nb     = (bins_r > 8'(NUM_BINS)) ? 8'(NUM_BINS) : bins_r;
  assign diff   = {smp_r[31], smp_r} - {min_r[31], min_r};
  assign add_hit = ok_r && (bin_r < {24'd0, nb});
  assign cnt_rd = vld_q ? cnt_q : 16'd0;
  assign avg_rd = vld_q ? avg_q : 32'd0;
  assign acc    = prod_r[DIVD_W-1:0] + {16'd0, cnt_rd, 16'd0};

  // Shared multiplier
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  hra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc),
    .divisor  (runs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.command)
            CMD_ADD:  state_nxt = ST_MUL;
            CMD_FOLD: state_nxt = ST_FRD;
            CMD_READ: state_nxt = ST_RD;
            default:  state_nxt = ST_OUT;
          endcase
        end
      end
      ST_MUL:  state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = add_hit ? ST_RMW : ST_OUT;
      ST_RMW:  state_nxt = ST_OUT;
      ST_RD:   state_nxt = ST_RDQ;
      ST_RDQ:  state_nxt = ST_OUT;
      ST_FRD:  state_nxt = ST_FMUL;
      ST_FMUL: state_nxt = ST_FACC;
      ST_FACC: state_nxt = ST_FDIV;
      ST_FDIV: state_nxt = div_done ? ST_FWR : ST_FDIV;
      ST_FWR:  state_nxt = (fb_r == BIN_W'(NUM_BINS-1)) ? ST_OUT : ST_FRD;
      ST_OUT:  state_nxt = out_free ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = fb_r;
    wr_en     = 1'b0;
    wr_addr   = fb_r;
    wr_cnt    = 16'd0;
    wr_avg    = div_q[31:0];
    mul_a     = diff[31:0];
    mul_b     = scale_r;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_LOOK: begin
        rd_en   = add_hit;
        rd_addr = bin_r[BIN_W-1:0];
      end
      ST_RMW: begin
        wr_en   = 1'b1;
        wr_addr = bin_r[BIN_W-1:0];
        wr_cnt  = (cnt_rd == 16'hFFFF) ? cnt_rd : cnt_rd + 16'd1;
        wr_avg  = avg_rd;
      end
      ST_RD: begin
        rd_en   = 1'b1;
        rd_addr = BIN_W'(sel_r);
      end
      ST_FRD:  rd_en = 1'b1;
      ST_FMUL: begin
        mul_a = avg_rd;
        mul_b = {16'd0, runs_r - 16'd1};
      end
      ST_FACC: div_start = 1'b1;
      ST_FWR:  wr_en = 1'b1;
      ST_OUT:  load_out = out_free;
      default: ;
    endcase
  end

  // Memories with registered reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cnt_q <= cnt_mem[rd_addr];
      avg_q <= avg_mem[rd_addr];
      vld_q <= vld_r[rd_addr];
    end
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_cnt;
      avg_mem[wr_addr] <= wr_avg;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      runs_r      <= 16'd0;
      min_r       <= MIN_RST;
      scale_r     <= SCALE_RST;
      bins_r      <= BINS_RST;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (in_fire && in_data.command == CMD_FOLD && runs_r != 16'hFFFF)
        runs_r <= runs_r + 16'd1;
      if (cfg_valid) begin
        case (cfg_index)
          REG_MIN:   min_r   <= cfg_data;
          REG_SCALE: scale_r <= cfg_data;
          REG_BINS:  bins_r  <= cfg_data[7:0];
          default:   ;
        endcase
      end
    end
  end

  // Working registers and the result being built
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r     <= in_data.command;
      smp_r     <= in_data.sample;
      sel_r     <= in_data.bin_select;
      fb_r      <= '0;
      res_idx_r <= (in_data.command == CMD_READ) ? in_data.bin_select : 7'd0;
      res_hit_r <= 1'b0;
      res_cnt_r <= 16'd0;
      res_avg_r <= 32'd0;
    end
    if (state_r == ST_MUL) begin
      ok_r  <= diff[32] ? (scale_r == 32'd0) : 1'b1;
      bin_r <= diff[32] ? 32'd0 : mul_p[63:32];
    end
    if (state_r == ST_FMUL) prod_r <= mul_p;
    if (state_r == ST_FWR) fb_r <= fb_r + 1'b1;
    if (state_r == ST_RMW) begin
      res_idx_r <= 7'(bin_r[BIN_W-1:0]);
      res_hit_r <= 1'b1;
      res_cnt_r <= wr_cnt;
      res_avg_r <= avg_rd;
    end
    if (state_r == ST_RDQ && {1'b0, sel_r} < nb) begin
      res_hit_r <= 1'b1;
      res_cnt_r <= cnt_rd;
      res_avg_r <= avg_rd;
    end
    if (load_out) begin
      out_data_r.bin_index   <= res_idx_r;
      out_data_r.in_range    <= res_hit_r;
      out_data_r.bin_count   <= res_cnt_r;
      out_data_r.bin_average <= res_avg_r;
      out_data_r.run_number  <= runs_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready) else $error("accepted a word back to back");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r) else $error("result dropped");
  a_runs_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 runs_r >= $past(runs_r)) else $error("run number went back");
  a_fold_div_ready: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> runs_r != 16'd0) else $error("fold with zero run number");
  a_unused_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FRD |-> cmd_r == CMD_FOLD) else $error("fold walk for other command");

endmodule

[sim/tb_histogram_with_running_average_unit.sv]
// Self-checking testbench for histogram_with_running_average_unit.
// Depends on hra_pkg and the RTL in src. A directed table and then random words are
// checked against a bin-count and running-average predictor or typed expected words.
module tb_histogram_with_running_average_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hra_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int LIMIT_CYCLES = 4000000;

  // Idling modes
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  histogram_with_running_average_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  logic signed [31:0] lo_edge;
  logic [31:0]        scale_q;
  logic [7:0]         bins_cfg;
  logic [15:0]        counts [NUM_BINS];
  logic [31:0]        avgs [NUM_BINS];
  logic [15:0]        runs;

  out_word_t pending_q [$];
  int        errors;
  int        idle_mode;
  longint    cycles;

  // Directed table row: typed rows carry their own expected word
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t exp;
  } row_t;
  row_t tbl [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bin and average after one word; updates the predictor state
  function automatic out_word_t predict_bin(in_word_t w);
    out_word_t r;
    logic signed [32:0] diff;
    logic [63:0] prod;
    logic [63:0] acc;
    logic [63:0] n;
    logic [31:0] bin;
    logic [31:0] nb;
    bit ok;
    r = '0;
    nb = (bins_cfg > NUM_BINS) ? NUM_BINS : bins_cfg;
    case (w.command)
      CMD_ADD: begin
        diff = $signed({w.sample[31], w.sample}) - $signed({lo_edge[31], lo_edge});
        bin = '0;
        if (diff < 0) begin
          ok = (scale_q == 0);
        end else begin
          prod = {32'd0, diff[31:0]} * {32'd0, scale_q};
          bin = prod[63:32];
          ok = 1'b1;
        end
        if (ok && bin < nb) begin
          if (counts[bin] != 16'hFFFF) counts[bin] = counts[bin] + 1'b1;
          r.bin_index = bin[6:0];
          r.in_range = 1'b1;
          r.bin_count = counts[bin];
          r.bin_average = avgs[bin];
        end
      end
      CMD_FOLD: begin
        if (runs != 16'hFFFF) runs = runs + 1'b1;
        n = {48'd0, runs};
        for (int b = 0; b < NUM_BINS; b++) begin
          acc = {32'd0, avgs[b]} * (n - 1) + ({48'd0, counts[b]} << 16);
          avgs[b] = 32'(acc / n);
          counts[b] = '0;
        end
      end
      CMD_READ: begin
        r.bin_index = w.bin_select;
        if ({25'd0, w.bin_select} < nb) begin
          r.in_range = 1'b1;
          r.bin_count = counts[w.bin_select];
          r.bin_average = avgs[w.bin_select];
        end
      end
      default: ;
    endcase
    r.run_number = runs;
    return r;
  endfunction

  function automatic in_word_t mk(logic [1:0] c, logic [31:0] s, logic [6:0] sel);
    in_word_t w;
    w.command = c;
    w.sample = s;
    w.bin_select = sel;
    return w;
  endfunction

  function automatic out_word_t ow(logic [6:0] i, logic h, logic [15:0] c,
                                   logic [31:0] a, logic [15:0] n);
    out_word_t o;
    o.bin_index = i;
    o.in_range = h;
    o.bin_count = c;
    o.bin_average = a;
    o.run_number = n;
    return o;
  endfunction

  // Offer one word, hold it until taken, then maybe leave a gap
  task automatic send_word(in_word_t w, bit typed = 0, out_word_t exp = '0);
    out_word_t p;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = w;
    do @(posedge clk); while (!in_ready);
    p = predict_bin(w);
    pending_q.push_back(typed ? exp : p);
    @(negedge clk);
    in_valid = 1'b0;
    if ((idle_mode == IDLE_SEND && $urandom_range(99) < 81) ||
        (idle_mode == IDLE_BOTH && $urandom_range(99) < 20))
      repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  // Wait for every result, plus a margin before touching registers
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN:   lo_edge = val;
      REG_SCALE: scale_q = val;
      REG_BINS:  bins_cfg = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random words aimed mostly at the active bins
  task automatic random_words(int num);
    logic [63:0] span;
    logic [31:0] s;
    logic [31:0] nb;
    int pick;
    nb = (bins_cfg > NUM_BINS) ? NUM_BINS : bins_cfg;
    span = (scale_q == 0) ? 64'd65536 : (({32'd0, nb} + 4) << 32) / scale_q + 1;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    for (int k = 0; k < num; k++) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) < 7)
        s = lo_edge + 32'($urandom % span[31:0]) - (($urandom_range(19) == 0) ? 32'd5 : 32'd0);
      else
        s = $urandom;
      if (pick < 80)       send_word(mk(CMD_ADD, s, 7'($urandom)));
      else if (pick < 81)  send_word(mk(CMD_FOLD, s, 7'($urandom)));
      else if (pick < 94)  send_word(mk(CMD_READ, s, 7'($urandom_range(127))));
      else                 send_word(mk(CMD_NOP, s, 7'($urandom)));
    end
  endtask

  // Receiver stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_mode == IDLE_RECV) out_ready = ($urandom_range(99) >= 81);
      else if (idle_mode == IDLE_BOTH) out_ready = ($urandom_range(99) >= 20);
      else out_ready = 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, out_data);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_data.bin_index !== e.bin_index) begin
          $display("%0t: bin_index exp %0d got %0d", $realtime, e.bin_index, out_data.bin_index);
          errors++;
        end
        if (out_data.in_range !== e.in_range) begin
          $display("%0t: in_range exp %0d got %0d", $realtime, e.in_range, out_data.in_range);
          errors++;
        end
        if (out_data.bin_count !== e.bin_count) begin
          $display("%0t: bin_count exp %0d got %0d", $realtime, e.bin_count, out_data.bin_count);
          errors++;
        end
        if (out_data.bin_average !== e.bin_average) begin
          $display("%0t: bin_average exp %h got %h", $realtime, e.bin_average,
                   out_data.bin_average);
          errors++;
        end
        if (out_data.run_number !== e.run_number) begin
          $display("%0t: run_number exp %0d got %0d", $realtime, e.run_number,
                   out_data.run_number);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Main sequence
  initial begin
    errors = 0;
    cycles = 0;
    idle_mode = IDLE_NONE;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN;
    cfg_data = '0;
    lo_edge = MIN_RST;
    scale_q = SCALE_RST;
    bins_cfg = BINS_RST;
    runs = '0;
    for (int b = 0; b < NUM_BINS; b++) begin
      counts[b] = '0;
      avgs[b] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table under reset defaults
    tbl.push_back('{mk(CMD_READ, 32'd0, 7'd0), 1, ow(7'd0, 1'b1, 16'd0, 32'd0, 16'd0)});
    tbl.push_back('{mk(CMD_READ, 32'd0, 7'd127), 1, ow(7'd127, 1'b0, 16'd0, 32'd0, 16'd0)});
    tbl.push_back('{mk(CMD_NOP, 32'hFFFF_FFFF, 7'h7F), 1, ow(7'd0, 1'b0, 16'd0, 32'd0, 16'd0)});
    tbl.push_back('{mk(CMD_ADD, 32'h8000_0000, 7'd0), 1, ow(7'd0, 1'b0, 16'd0, 32'd0, 16'd0)});
    tbl.push_back('{mk(CMD_ADD, 32'h7FFF_FFFF, 7'd0), 1, ow(7'd0, 1'b0, 16'd0, 32'd0, 16'd0)});
    tbl.push_back('{mk(CMD_ADD, MIN_RST, 7'd0), 1, ow(7'd0, 1'b1, 16'd1, 32'd0, 16'd0)});
    tbl.push_back('{mk(CMD_ADD, MIN_RST - 1, 7'd0), 0, '0});
    tbl.push_back('{mk(CMD_ADD, 32'd0, 7'd0), 0, '0});
    tbl.push_back('{mk(CMD_ADD, 32'd0, 7'd0), 0, '0});
    tbl.push_back('{mk(CMD_ADD, 32'h0002_FFFF, 7'd0), 0, '0});
    tbl.push_back('{mk(CMD_ADD, 32'h0003_0000, 7'd0), 0, '0});
    tbl.push_back('{mk(CMD_FOLD, 32'd0, 7'd0), 1, ow(7'd0, 1'b0, 16'd0, 32'd0, 16'd1)});
    tbl.push_back('{mk(CMD_READ, 32'd0, 7'd50), 0, '0});
    tbl.push_back('{mk(CMD_READ, 32'd0, 7'd99), 0, '0});
    tbl.push_back('{mk(CMD_READ, 32'd0, 7'd100), 0, '0});
    tbl.push_back('{mk(CMD_ADD, 32'd0, 7'd0), 0, '0});
    tbl.push_back('{mk(CMD_FOLD, 32'd0, 7'd0), 0, '0});
    tbl.push_back('{mk(CMD_READ, 32'd0, 7'd50), 0, '0});
    tbl.push_back('{mk(CMD_READ, 32'd0, 7'd0), 0, '0});
    foreach (tbl[i]) send_word(tbl[i].w, tbl[i].typed, tbl[i].exp);

    // Bin 0 read, folded and read back, no idling
    send_word(mk(CMD_READ, 32'd0, 7'd0));
    send_word(mk(CMD_FOLD, 32'd0, 7'd0));
    send_word(mk(CMD_READ, 32'd0, 7'd0));

    // Random phases across register settings and idling modes
    for (int ph = 0; ph < 7; ph++) begin
      idle_mode = ph % 4;
      case (ph)
        1: begin
          write_reg(REG_MIN, 32'h8000_0000);
          write_reg(REG_SCALE, 32'hFFFF_FFFF);
          write_reg(REG_BINS, 8'd128);
        end
        2: begin
          write_reg(REG_MIN, 32'h7FFF_FFFF);
          write_reg(REG_SCALE, 32'd0);
          write_reg(REG_BINS, 8'd1);
        end
        3: begin
          write_reg(REG_MIN, $urandom);
          write_reg(REG_SCALE, $urandom_range(32'h0010_0000, 32'd4096));
          write_reg(REG_BINS, 8'd255);
        end
        4: write_reg(REG_BINS, 8'd0);
        5: begin
          write_reg(REG_MIN, 32'd0);
          write_reg(REG_SCALE, 32'h0001_0000);
          write_reg(REG_BINS, 8'd64);
        end
        6: begin
          write_reg(REG_MIN, MIN_RST);
          write_reg(REG_SCALE, SCALE_RST);
          write_reg(REG_BINS, BINS_RST);
        end
        default: ;
      endcase
      random_words(130);
      // hold off until the block has caught up, then carry on
      while (pending_q.size() != 0) @(posedge clk);
      random_words(130);
    end

    in_valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
src/hra_pkg.sv
src/hra_div.sv
src/histogram_with_running_average_unit.sv
sim/tb_histogram_with_running_average_unit.sv
